// ===== hw/rtl/mer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg: shared definitions of the midpoint ellipse rasterizer
// Default sizes, configuration register indexes, region codes, datapath
// operation codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

    // Default sizes of the semi-axes and the centre coordinates.
    localparam int AXIS_BITS_DEF  = 9;
    localparam int COORD_BITS_DEF = 11;

    // Width of an emitted pixel coordinate (two's complement).
    localparam int PIX_BITS = 13;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_CENTER_X    = 2'd0;
    localparam cfg_idx_t REG_CENTER_Y    = 2'd1;
    localparam cfg_idx_t REG_SEMI_AXIS_X = 2'd2;
    localparam cfg_idx_t REG_SEMI_AXIS_Y = 2'd3;

    // Region of the midpoint walk.
    typedef logic [1:0] phase_t;
    localparam phase_t PH_IDLE = 2'd0;
    localparam phase_t PH_REG1 = 2'd1;
    localparam phase_t PH_REG2 = 2'd2;

    // Datapath operations, one per cycle.
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_SQ_A     = 4'd1;   // a2 = a * a
    localparam op_t OP_SQ_B     = 4'd2;   // b2 = b * b
    localparam op_t OP_INIT_MUL = 4'd3;   // prod = a2 * b
    localparam op_t OP_INIT_SET = 4'd4;   // load the top point and start terms
    localparam op_t OP_T2       = 4'd5;   // tmp = (2x+1)^2
    localparam op_t OP_E1       = 4'd6;   // dec = b2 * tmp
    localparam op_t OP_U2       = 4'd7;   // tmp = (y-1)^2
    localparam op_t OP_E2       = 4'd8;   // prod = a2 * tmp
    localparam op_t OP_E3       = 4'd9;   // dec += 4 prod, prod = a2 * b2
    localparam op_t OP_E4       = 4'd10;  // dec -= 4 prod, enter region 2
    localparam op_t OP_MOVE     = 4'd11;  // pick the next pixel
    localparam op_t OP_SX       = 4'd12;  // slope_x = 2 b2 x
    localparam op_t OP_SY       = 4'd13;  // slope_y = 2 a2 y
    localparam op_t OP_UPD      = 4'd14;  // advance the decision term

    // Controller to datapath.
    typedef struct packed {
        op_t        op;
        logic       emit_load;
        logic [1:0] emit_quad;
    } mer_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        phase_t phase;
        logic   enter_r2;
        logic   out_free;
    } mer_stat_t;

endpackage

// ===== hw/rtl/mer_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl: sequencer of the midpoint ellipse rasterizer
// Accepts one item at a time, steps the datapath through the multiply and
// update operations of a restart or an advance, then hands the four mirrored
// pixels to the output register one by one (none with no ellipse running).
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    output mer_pkg::mer_cmd_t  cmd,
    input  mer_pkg::mer_stat_t stat
);
    import mer_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQA  = 4'd1;
    localparam logic [3:0] S_SQB  = 4'd2;
    localparam logic [3:0] S_IMUL = 4'd3;
    localparam logic [3:0] S_ISET = 4'd4;
    localparam logic [3:0] S_T2   = 4'd5;
    localparam logic [3:0] S_E1   = 4'd6;
    localparam logic [3:0] S_U2   = 4'd7;
    localparam logic [3:0] S_E2   = 4'd8;
    localparam logic [3:0] S_E3   = 4'd9;
    localparam logic [3:0] S_E4   = 4'd10;
    localparam logic [3:0] S_MOVE = 4'd11;
    localparam logic [3:0] S_SX   = 4'd12;
    localparam logic [3:0] S_SY   = 4'd13;
    localparam logic [3:0] S_UPD  = 4'd14;
    localparam logic [3:0] S_EMIT = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       restart_reg, restart_next;
    logic [1:0] quad_reg, quad_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Next state and the operation issued in each state.
    always_comb
    begin
        state_next    = state_reg;
        restart_next  = restart_reg;
        quad_next     = quad_reg;
        cmd.op        = OP_NOP;
        cmd.emit_load = 1'b0;
        cmd.emit_quad = quad_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    restart_next = restart;
                    state_next   = S_SQA;
                end
            end
            S_SQA:
            begin
                cmd.op     = OP_SQ_A;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                cmd.op = OP_SQ_B;
                if (restart_reg)
                    state_next = S_IMUL;
                else if (stat.phase == PH_IDLE)
                    state_next = S_IDLE;
                else if (stat.enter_r2)
                    state_next = S_T2;
                else
                    state_next = S_MOVE;
            end
            S_IMUL:
            begin
                cmd.op     = OP_INIT_MUL;
                state_next = S_ISET;
            end
            S_ISET:
            begin
                cmd.op     = OP_INIT_SET;
                state_next = S_EMIT;
            end
            S_T2:
            begin
                cmd.op     = OP_T2;
                state_next = S_E1;
            end
            S_E1:
            begin
                cmd.op     = OP_E1;
                state_next = S_U2;
            end
            S_U2:
            begin
                cmd.op     = OP_U2;
                state_next = S_E2;
            end
            S_E2:
            begin
                cmd.op     = OP_E2;
                state_next = S_E3;
            end
            S_E3:
            begin
                cmd.op     = OP_E3;
                state_next = S_E4;
            end
            S_E4:
            begin
                cmd.op     = OP_E4;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.op     = OP_MOVE;
                state_next = S_SX;
            end
            S_SX:
            begin
                cmd.op     = OP_SX;
                state_next = S_SY;
            end
            S_SY:
            begin
                cmd.op     = OP_SY;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op     = OP_UPD;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // One mirrored pixel each time the output register is free.
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    quad_next     = quad_reg + 2'd1;
                    if (quad_reg == 2'd3)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            restart_reg <= 1'b0;
            quad_reg    <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            restart_reg <= restart_next;
            quad_reg    <= quad_next;
        end
    end

endmodule

// ===== hw/rtl/mer_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_datapath: arithmetic of the midpoint ellipse rasterizer
// Holds the configuration registers, the walk state and the decision terms,
// one shared multiplier with a registered result, and the output register
// that presents one mirrored pixel at a time.
// ----------------------------------------------------------------------------
module mer_datapath #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [mer_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  logic [(COORD_BITS > AXIS_BITS ? COORD_BITS : AXIS_BITS)-1:0] cfg_data,
    input  mer_pkg::mer_cmd_t                         cmd,
    output mer_pkg::mer_stat_t                        stat,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [mer_pkg::PIX_BITS-1:0]       pixel_x,
    output logic signed [mer_pkg::PIX_BITS-1:0]       pixel_y,
    output logic [1:0]                                quadrant,
    output logic                                      last,
    output logic                                      done_res
);
    import mer_pkg::*;

    localparam int SQ_BITS    = 2 * AXIS_BITS;
    localparam int MUL_W      = 2 * AXIS_BITS + 2;
    localparam int PROD_BITS  = 2 * MUL_W;
    localparam int DEC_BITS   = 4 * AXIS_BITS + 6;
    localparam int SLOPE_BITS = 3 * AXIS_BITS + 3;
    localparam int MAX_CA     = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS;
    localparam int PIX_CALC   = ((MAX_CA > PIX_BITS) ? MAX_CA : PIX_BITS) + 1;

    // Configuration registers.
    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [AXIS_BITS-1:0]  ax_reg, by_reg;

    // Walk state and working terms.
    logic [SQ_BITS-1:0]         a2_reg, a2_next, b2_reg, b2_next;
    logic [MUL_W-1:0]           tmp_reg, tmp_next;
    logic [PROD_BITS-1:0]       prod_reg, prod_next;
    logic signed [DEC_BITS-1:0] dec_reg, dec_next;
    logic [SLOPE_BITS-1:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic [AXIS_BITS-1:0]       x_reg, x_next, y_reg, y_next;
    logic                       dir_reg, dir_next;
    logic                       done_reg, done_next;
    phase_t                     phase_reg, phase_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic signed [PIX_BITS-1:0] px_reg, py_reg;
    logic [1:0]                 quad_reg;
    logic                       last_reg, done_out_reg;

    // Shared multiplier.
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [PROD_BITS-1:0] mul_p;

    // Operands widened into the decision domain.
    logic signed [DEC_BITS-1:0] prod_d, a2_d, b2_d, sx_d, sy_d;
    logic [AXIS_BITS:0]         t_val;
    logic [AXIS_BITS-1:0]       u_val;
    logic                       in_r1, dec_neg, dec_zero, dir_move;

    // Pixel arithmetic.
    logic [PIX_CALC-1:0] cx_w, cy_w, x_w, y_w, px_w, py_w;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            ax_reg <= '0;
            by_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X:    cx_reg <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:    cy_reg <= cfg_data[COORD_BITS-1:0];
                REG_SEMI_AXIS_X: ax_reg <= cfg_data[AXIS_BITS-1:0];
                REG_SEMI_AXIS_Y: by_reg <= cfg_data[AXIS_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign t_val = {x_reg, 1'b1};
    assign u_val = y_reg - AXIS_BITS'(1);

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ_A:
            begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
            end
            OP_SQ_B:
            begin
                mul_a = MUL_W'(by_reg);
                mul_b = MUL_W'(by_reg);
            end
            OP_INIT_MUL:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(by_reg);
            end
            OP_T2:
            begin
                mul_a = MUL_W'(t_val);
                mul_b = MUL_W'(t_val);
            end
            OP_E1:
            begin
                mul_a = MUL_W'(b2_reg);
                mul_b = tmp_reg;
            end
            OP_U2:
            begin
                mul_a = MUL_W'(u_val);
                mul_b = MUL_W'(u_val);
            end
            OP_E2:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = tmp_reg;
            end
            OP_E3:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(b2_reg);
            end
            OP_SX:
            begin
                mul_a = MUL_W'(b2_reg);
                mul_b = MUL_W'(x_reg);
            end
            OP_SY:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign prod_d = $signed(DEC_BITS'(prod_reg));
    assign a2_d   = $signed(DEC_BITS'(a2_reg));
    assign b2_d   = $signed(DEC_BITS'(b2_reg));
    assign sx_d   = $signed(DEC_BITS'(sx_reg));
    assign sy_d   = $signed(DEC_BITS'(sy_reg));

    // Step direction: region 1 moves down on a non-negative decision,
    // region 2 moves right on a decision that is not positive.
    assign in_r1    = (phase_reg == PH_REG1);
    assign dec_neg  = dec_reg[DEC_BITS-1];
    assign dec_zero = (dec_reg == '0);
    assign dir_move = in_r1 ? !dec_neg : (dec_neg || dec_zero);

    // Walk state update, one operation per cycle.
    always_comb
    begin
        a2_next    = a2_reg;
        b2_next    = b2_reg;
        tmp_next   = tmp_reg;
        prod_next  = prod_reg;
        dec_next   = dec_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dir_next   = dir_reg;
        done_next  = done_reg;
        phase_next = phase_reg;
        case (cmd.op)
            OP_SQ_A:
            begin
                a2_next = mul_p[SQ_BITS-1:0];
            end
            OP_SQ_B:
            begin
                b2_next = mul_p[SQ_BITS-1:0];
            end
            OP_INIT_MUL:
            begin
                prod_next = mul_p;
            end
            OP_INIT_SET:
            begin
                x_next     = '0;
                y_next     = by_reg;
                dec_next   = (b2_d <<< 2) - (prod_d <<< 2) + a2_d;
                sx_next    = '0;
                sy_next    = {prod_reg[SLOPE_BITS-2:0], 1'b0};
                done_next  = (by_reg == '0);
                phase_next = (by_reg == '0) ? PH_IDLE : PH_REG1;
            end
            OP_T2:
            begin
                tmp_next = mul_p[MUL_W-1:0];
            end
            OP_E1:
            begin
                dec_next = $signed(DEC_BITS'(mul_p));
            end
            OP_U2:
            begin
                tmp_next = mul_p[MUL_W-1:0];
            end
            OP_E2:
            begin
                prod_next = mul_p;
            end
            OP_E3:
            begin
                dec_next  = dec_reg + (prod_d <<< 2);
                prod_next = mul_p;
            end
            OP_E4:
            begin
                dec_next   = dec_reg - (prod_d <<< 2);
                phase_next = PH_REG2;
            end
            OP_MOVE:
            begin
                dir_next = dir_move;
                if (in_r1)
                begin
                    x_next = x_reg + AXIS_BITS'(1);
                    y_next = y_reg - AXIS_BITS'(dir_move);
                end
                else
                begin
                    x_next = x_reg + AXIS_BITS'(dir_move);
                    y_next = y_reg - AXIS_BITS'(1);
                end
            end
            OP_SX:
            begin
                sx_next = {mul_p[SLOPE_BITS-2:0], 1'b0};
            end
            OP_SY:
            begin
                sy_next = {mul_p[SLOPE_BITS-2:0], 1'b0};
            end
            OP_UPD:
            begin
                if (in_r1)
                    dec_next = dec_reg + (sx_d <<< 2) + (b2_d <<< 2)
                             - (dir_reg ? (sy_d <<< 2) : '0);
                else
                    dec_next = dec_reg + (a2_d <<< 2) - (sy_d <<< 2)
                             + (dir_reg ? (sx_d <<< 2) : '0);
                done_next  = (y_reg == '0);
                phase_next = (y_reg == '0) ? PH_IDLE : phase_reg;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a2_reg   <= a2_next;
        b2_reg   <= b2_next;
        tmp_reg  <= tmp_next;
        prod_reg <= prod_next;
        dec_reg  <= dec_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        dir_reg  <= dir_next;
        done_reg <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    // Mirrored pixel for the quadrant the controller selects.
    assign cx_w = PIX_CALC'(cx_reg);
    assign cy_w = PIX_CALC'(cy_reg);
    assign x_w  = PIX_CALC'(x_reg);
    assign y_w  = PIX_CALC'(y_reg);
    assign px_w = cmd.emit_quad[0] ? (cx_w - x_w) : (cx_w + x_w);
    assign py_w = cmd.emit_quad[1] ? (cy_w - y_w) : (cy_w + y_w);

    // Output register: loaded when free, cleared when its item is taken.
    always_comb
    begin
        if (cmd.emit_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            px_reg       <= $signed(px_w[PIX_BITS-1:0]);
            py_reg       <= $signed(py_w[PIX_BITS-1:0]);
            quad_reg     <= cmd.emit_quad;
            last_reg     <= (cmd.emit_quad == 2'd3);
            done_out_reg <= done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign quadrant  = quad_reg;
    assign last      = last_reg;
    assign done_res  = done_out_reg;

    // Status for the controller.
    assign stat.phase    = phase_reg;
    assign stat.enter_r2 = in_r1 && (sx_reg > sy_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;

endmodule

// ===== hw/rtl/midpoint_ellipse_rasterizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core: axis-aligned midpoint ellipse rasterizer
// Walks one quarter of an ellipse point by point and emits each point's four
// mirrored pixels on the result channel.
// ----------------------------------------------------------------------------
// A restart item loads the top point (0, b) and emits its four pixels; each
// advance item moves one point along the curve and emits that point's four
// pixels in quadrant order, the fourth carrying last, all four carrying
// done_res once the walk reaches y = 0. An advance item while no ellipse is
// running emits nothing. One item is worked on at a time, on a single shared
// multiplier with a registered result: a restart squares both semi-axes,
// forms a2 * b and loads the top point; an advance squares both semi-axes,
// moves, forms both slopes and advances the decision term, and the advance
// that crosses from region 1 into region 2 first rebuilds the decision term
// for region 2. The four pixels then move into the output register one by
// one, later when the result side stalls. An advance with no ellipse running
// only squares both semi-axes. The input side is free again in the cycle
// after the fourth pixel is loaded into the output register. The centre and
// semi-axes are read at each item; write them only between items.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core #(
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [(COORD_BITS > AXIS_BITS ? COORD_BITS : AXIS_BITS)-1:0] cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mer_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [mer_pkg::PIX_BITS-1:0] pixel_y,
    output logic [1:0]                          quadrant,
    output logic                                last,
    output logic                                done_res
);
    import mer_pkg::*;

    mer_cmd_t  cmd;
    mer_stat_t stat;

    // Sequencer.
    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Arithmetic, state and output register.
    mer_datapath #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .quadrant  (quadrant),
        .last      (last),
        .done_res  (done_res)
    );

endmodule
